### sv/hctr_pkg.sv
// Package for the chained hash table with replacement.
// Holds the sequencer state type, status and function codes, and fixed field widths.
// No dependencies.
package hctr_pkg;

	localparam int KEY_W  = 31;
	localparam int SLOT_W = 5;
	localparam int LINK_W = 6;
	localparam int CFG_W  = 6;
	localparam int IDX_W  = 5;

	localparam logic [CFG_W-1:0]  TABLE_SIZE_RST = 6'd32;
	localparam logic [LINK_W-1:0] LINK_NONE      = 6'h3F;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	localparam logic [1:0] STATUS_INSERTED = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_READ     = 2'd2;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ_REQ,
		ST_READ_DATA,
		ST_HASH_KEY,
		ST_HOME_REQ,
		ST_HOME_CHK,
		ST_PROBE_REQ,
		ST_PROBE_CHK,
		ST_HASH_OLD,
		ST_TAIL_REQ,
		ST_TAIL_CHK,
		ST_PRED_REQ,
		ST_PRED_CHK,
		ST_PLACE,
		ST_LINK_REQ,
		ST_LINK_WR,
		ST_HOME_WR,
		ST_RESP
	} state_t;

endpackage

### sv/hctr_mod.sv
// Bit-serial remainder unit: key modulo the active table size.
// Restoring division, one dividend bit per cycle. Uses hctr_pkg.
module hctr_mod import hctr_pkg::*; #(
	parameter int DW = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] dividend,
	input  logic [DW-1:0]    divisor,
	output logic             done,
	output logic [DW-1:0]    remainder
);

	localparam int CNT_W = $clog2(KEY_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [KEY_W-1:0] dvd_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    div_q;

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic [DW-1:0] rem_nx;

	// remainder stays below the divisor, so the shifted trial fits DW+1 bits
	assign trial  = {rem_q, dvd_q[KEY_W-1]};
	assign diff   = trial - {1'b0, div_q};
	assign rem_nx = (trial >= {1'b0, div_q}) ? diff[DW-1:0] : trial[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(KEY_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

### sv/hash_table_chain_with_replacement.sv
// Chained hash table with replacement (coalesced hashing), top level.
// Depends on hctr_pkg and the remainder unit hctr_mod.
//
// Each input transaction is either an insert (func 0) or a slot read (func 1) and
// yields exactly one result transaction. The home slot of a key is key modulo the
// active table size (table_size clamped to 1..SLOTS); it is computed by a bit-serial
// remainder unit, shared with the second remainder needed when a resident key from
// another home must be displaced. All slot state lives in one single-port-style
// array (one write, one registered read per cycle) walked by a small sequencer, so
// every probe or chain step takes a request state and a check state. A read passes
// through a request, a data and a response state. An insert into a free home slot
// needs the remainder, a home read and the response; a collision adds probing of
// slots, the second remainder, chain steps (predecessor search plus tail walk, each
// bounded by SLOTS steps) and the writes. The block takes no new transaction while
// one is in progress, but accepts the next while a finished result still waits in
// the output register. After reset a clearing pass writes every slot empty before
// the first transaction is accepted; the table_size register can be written during
// that pass. Duplicates are not detected.
module hash_table_chain_with_replacement import hctr_pkg::*; #(
	parameter int SLOTS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     cfg_wr_en,
	input  logic [CFG_W-1:0]         cfg_wr_data,
	// request channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     func,
	input  logic [KEY_W-1:0]         key,
	input  logic [IDX_W-1:0]         slot_index,
	// result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               status,
	output logic [SLOT_W-1:0]        slot,
	output logic [KEY_W-1:0]         slot_key,
	output logic                     occupied,
	output logic signed [LINK_W-1:0] next_link
);

	localparam int AW = $clog2(SLOTS);   // slot address width
	localparam int NW = AW + 1;          // counts up to SLOTS

	// one table entry; a missing successor is has_link = 0
	typedef struct packed {
		logic             used;
		logic             has_link;
		logic [AW-1:0]    link;
		logic [KEY_W-1:0] key;
	} entry_t;

	state_t state_q, state_d;

	logic [CFG_W-1:0] table_size_q;
	logic [AW-1:0]    clr_addr_q;
	logic             out_valid_q;

	// table storage
	entry_t mem [SLOTS];
	entry_t rd_data_q;
	logic   mem_rd_en;
	logic [AW-1:0] mem_rd_addr;
	logic   mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	entry_t mem_wr_data;

	// per-transaction working registers
	logic [KEY_W-1:0] key_q;
	logic [AW-1:0]    rd_slot_q;
	logic [AW-1:0]    home_q;      // home of the new key
	logic [AW-1:0]    j_q;         // probe position / free slot
	logic [NW-1:0]    cnt_q;       // probe count
	logic [AW-1:0]    cur_q;       // chain walk position
	logic [NW-1:0]    steps_q;     // chain walk step count
	logic [AW-1:0]    hh_q;        // home of the resident key
	logic [KEY_W-1:0] hkey_q;      // resident key of the home slot
	logic             hlink_has_q;
	logic [AW-1:0]    hlink_q;
	logic [AW-1:0]    tail_q;
	logic             displace_q;  // resident key belongs elsewhere
	logic             fixup_q;     // predecessor not found: tail at home maps to its own home

	// staged result, then output register
	logic [1:0]        res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [KEY_W-1:0]  res_key_q;
	logic              res_occ_q;
	logic [LINK_W-1:0] res_link_q;

	logic [1:0]        out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [KEY_W-1:0]  out_key_q;
	logic              out_occ_q;
	logic [LINK_W-1:0] out_link_q;

	// remainder unit
	logic             mod_start;
	logic [KEY_W-1:0] mod_dividend;
	logic             mod_done;
	logic [NW-1:0]    mod_rem;

	// shared combinational helpers
	logic [31:0]   ts_ext;
	logic [NW-1:0] act_n;
	logic          in_acc;
	logic          out_free;
	logic [AW-1:0] inc_base;
	logic [NW-1:0] inc_sum;
	logic [AW-1:0] j_inc;
	logic [NW-1:0] cnt_inc;
	logic [NW-1:0] steps_inc;
	logic          steps_last;
	logic          probe_full;
	logic          pred_hit;
	logic [AW-1:0] tail_raw;
	logic [AW-1:0] tail_fix;

	// active size: zero counts as one, above SLOTS clamps to SLOTS
	assign ts_ext = {{(32-CFG_W){1'b0}}, table_size_q};
	always_comb begin
		if (ts_ext == 32'd0) begin
			act_n = NW'(1);
		end else if (ts_ext > 32'(SLOTS)) begin
			act_n = NW'(SLOTS);
		end else begin
			act_n = NW'(ts_ext);
		end
	end

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// linear probe step, wrapping inside the active size
	assign inc_base  = (state_q == ST_HOME_CHK) ? home_q : j_q;
	assign inc_sum   = {1'b0, inc_base} + NW'(1);
	assign j_inc     = (inc_sum == act_n) ? '0 : inc_sum[AW-1:0];
	assign cnt_inc   = cnt_q + NW'(1);
	assign probe_full = (cnt_inc == act_n);

	assign steps_inc  = steps_q + NW'(1);
	assign steps_last = (steps_inc == NW'(SLOTS));

	assign pred_hit = rd_data_q.has_link && (rd_data_q.link == home_q);
	assign tail_raw = rd_data_q.has_link ? rd_data_q.link : cur_q;
	assign tail_fix = (fixup_q && (tail_raw == home_q)) ? hh_q : tail_raw;

	hctr_mod #(
		.DW (NW)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (mod_dividend),
		.divisor   (act_n),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == AW'(SLOTS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_acc) state_d = (func == FUNC_READ) ? ST_READ_REQ : ST_HASH_KEY;
			end
			ST_READ_REQ:  state_d = ST_READ_DATA;
			ST_READ_DATA: state_d = ST_RESP;
			ST_HASH_KEY: begin
				if (mod_done) state_d = ST_HOME_REQ;
			end
			ST_HOME_REQ: state_d = ST_HOME_CHK;
			ST_HOME_CHK: begin
				if (!rd_data_q.used) begin
					state_d = ST_RESP;
				end else if (act_n == NW'(1)) begin
					state_d = ST_RESP;
				end else begin
					state_d = ST_PROBE_REQ;
				end
			end
			ST_PROBE_REQ: state_d = ST_PROBE_CHK;
			ST_PROBE_CHK: begin
				if (!rd_data_q.used) begin
					state_d = ST_HASH_OLD;
				end else if (probe_full) begin
					state_d = ST_RESP;
				end else begin
					state_d = ST_PROBE_REQ;
				end
			end
			ST_HASH_OLD: begin
				if (mod_done) state_d = (mod_rem[AW-1:0] == home_q) ? ST_TAIL_REQ : ST_PRED_REQ;
			end
			ST_TAIL_REQ: state_d = ST_TAIL_CHK;
			ST_TAIL_CHK: begin
				if (!rd_data_q.has_link || steps_last) begin
					state_d = ST_PLACE;
				end else begin
					state_d = ST_TAIL_REQ;
				end
			end
			ST_PRED_REQ: state_d = ST_PRED_CHK;
			ST_PRED_CHK: begin
				if (pred_hit || !rd_data_q.has_link || steps_last) begin
					state_d = ST_TAIL_REQ;
				end else begin
					state_d = ST_PRED_REQ;
				end
			end
			ST_PLACE:    state_d = ST_LINK_REQ;
			ST_LINK_REQ: state_d = ST_LINK_WR;
			ST_LINK_WR:  state_d = displace_q ? ST_HOME_WR : ST_RESP;
			ST_HOME_WR:  state_d = ST_RESP;
			ST_RESP: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory and remainder unit control
	always_comb begin
		mem_rd_en    = 1'b0;
		mem_rd_addr  = cur_q;
		mem_wr_en    = 1'b0;
		mem_wr_addr  = home_q;
		mem_wr_data  = rd_data_q;
		mod_start    = 1'b0;
		mod_dividend = hkey_q;
		case (state_q)
			ST_CLEAR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = clr_addr_q;
				mem_wr_data = '0;
			end
			ST_IDLE: begin
				mod_start    = in_acc && (func == FUNC_INSERT);
				mod_dividend = key;
			end
			ST_READ_REQ: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = rd_slot_q;
			end
			ST_HOME_REQ: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = home_q;
			end
			ST_HOME_CHK: begin
				mem_wr_en   = !rd_data_q.used;
				mem_wr_addr = home_q;
				mem_wr_data = '{used: 1'b1, has_link: 1'b0, link: '0, key: key_q};
			end
			ST_PROBE_REQ: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = j_q;
			end
			ST_PROBE_CHK: begin
				mod_start = !rd_data_q.used;
			end
			ST_TAIL_REQ, ST_PRED_REQ: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = cur_q;
			end
			ST_PRED_CHK: begin
				// unlink the displaced key: predecessor inherits its successor
				mem_wr_en            = pred_hit;
				mem_wr_addr          = cur_q;
				mem_wr_data          = rd_data_q;
				mem_wr_data.has_link = hlink_has_q;
				mem_wr_data.link     = hlink_q;
			end
			ST_PLACE: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = j_q;
				mem_wr_data = '{used: 1'b1, has_link: 1'b0, link: '0,
					key: (displace_q ? hkey_q : key_q)};
			end
			ST_LINK_REQ: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = tail_q;
			end
			ST_LINK_WR: begin
				mem_wr_en            = 1'b1;
				mem_wr_addr          = tail_q;
				mem_wr_data          = rd_data_q;
				mem_wr_data.has_link = 1'b1;
				mem_wr_data.link     = j_q;
			end
			ST_HOME_WR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = home_q;
				mem_wr_data = '{used: 1'b1, has_link: 1'b0, link: '0, key: key_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_wr_en) mem[mem_wr_addr] <= mem_wr_data;
		if (mem_rd_en) rd_data_q <= mem[mem_rd_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_addr_q   <= '0;
			out_valid_q  <= 1'b0;
			table_size_q <= TABLE_SIZE_RST;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
			if (cfg_wr_en) table_size_q <= cfg_wr_data;
			if ((state_q == ST_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					key_q      <= key;
					rd_slot_q  <= AW'(32'(slot_index) % SLOTS);
					res_key_q  <= '0;
					res_occ_q  <= 1'b0;
					res_link_q <= LINK_NONE;
				end
			end
			ST_READ_DATA: begin
				res_status_q <= STATUS_READ;
				res_slot_q   <= SLOT_W'(32'(rd_slot_q));
				res_key_q    <= rd_data_q.used ? rd_data_q.key : '0;
				res_occ_q    <= rd_data_q.used;
				res_link_q   <= rd_data_q.has_link ? LINK_W'(32'(rd_data_q.link)) : LINK_NONE;
			end
			ST_HASH_KEY: begin
				if (mod_done) home_q <= mod_rem[AW-1:0];
			end
			ST_HOME_CHK: begin
				hkey_q      <= rd_data_q.key;
				hlink_has_q <= rd_data_q.has_link;
				hlink_q     <= rd_data_q.link;
				j_q         <= j_inc;
				cnt_q       <= NW'(1);
				if (!rd_data_q.used) begin
					res_status_q <= STATUS_INSERTED;
					res_slot_q   <= SLOT_W'(32'(home_q));
				end else begin
					res_status_q <= STATUS_FULL;
					res_slot_q   <= '0;
				end
			end
			ST_PROBE_CHK: begin
				if (rd_data_q.used) begin
					j_q   <= j_inc;
					cnt_q <= cnt_inc;
					res_status_q <= STATUS_FULL;
					res_slot_q   <= '0;
				end
			end
			ST_HASH_OLD: begin
				if (mod_done) begin
					hh_q       <= mod_rem[AW-1:0];
					displace_q <= (mod_rem[AW-1:0] != home_q);
					cur_q      <= (mod_rem[AW-1:0] == home_q) ? home_q : mod_rem[AW-1:0];
					steps_q    <= '0;
					fixup_q    <= 1'b0;
				end
			end
			ST_TAIL_CHK: begin
				if (!rd_data_q.has_link || steps_last) begin
					tail_q <= tail_fix;
				end else begin
					cur_q   <= rd_data_q.link;
					steps_q <= steps_inc;
				end
			end
			ST_PRED_CHK: begin
				if (pred_hit) begin
					steps_q <= '0;
				end else if (!rd_data_q.has_link || steps_last) begin
					// no predecessor: walk the resident key's own chain from its home
					cur_q   <= hh_q;
					steps_q <= '0;
					fixup_q <= 1'b1;
				end else begin
					cur_q   <= rd_data_q.link;
					steps_q <= steps_inc;
				end
			end
			ST_LINK_WR: begin
				res_status_q <= STATUS_INSERTED;
				res_slot_q   <= SLOT_W'(32'(j_q));
			end
			ST_HOME_WR: begin
				res_status_q <= STATUS_INSERTED;
				res_slot_q   <= SLOT_W'(32'(home_q));
			end
			ST_RESP: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_slot_q   <= res_slot_q;
					out_key_q    <= res_key_q;
					out_occ_q    <= res_occ_q;
					out_link_q   <= res_link_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign slot      = out_slot_q;
	assign slot_key  = out_key_q;
	assign occupied  = out_occ_q;
	assign next_link = out_link_q;

endmodule

### sv/hctr_chk.sv
// Port-level checker for the chained hash table, bound to the top level.
// Uses hctr_pkg status codes.
module hctr_chk import hctr_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [1:0]               status,
	input logic [SLOT_W-1:0]        slot,
	input logic [KEY_W-1:0]         slot_key,
	input logic                     occupied,
	input logic signed [LINK_W-1:0] next_link
);

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// one transaction at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction accepted back to back");

	// insert and full results carry empty slot fields
	a_insert_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STATUS_READ) |->
			(slot_key == '0) && !occupied && (next_link == -6'sd1))
		else $error("insert result carries slot data");

	// full reports slot zero
	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_FULL) |-> (slot == '0))
		else $error("full result with nonzero slot");

	// an empty slot reads as key zero
	a_empty_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_READ) && !occupied |-> (slot_key == '0))
		else $error("empty slot returned a key");

endmodule

bind hash_table_chain_with_replacement hctr_chk u_hctr_chk (.*);
